FILE: design/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebAssembly section deframer: result
// status codes, configuration register indexes and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    // Depth of the queue between parser and output stage
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [2:0] CFG_MAGIC_WORD       = 3'd0;
    localparam logic [2:0] CFG_VERSION_WORD     = 3'd1;
    localparam logic [2:0] CFG_SECTION_ID_LIMIT = 3'd2;
    localparam logic [2:0] CFG_CODE_SECTION_ID  = 3'd3;

    // Reset values of the configuration registers
    localparam logic [31:0] MAGIC_RESET   = 32'h6D73_6100;
    localparam logic [31:0] VERSION_RESET = 32'h0000_0001;
    localparam logic [7:0]  ID_LIMIT_RESET  = 8'd12;
    localparam logic [7:0]  CODE_ID_RESET   = 8'd10;

    // Record kinds
    localparam logic REC_SECTION = 1'b0;
    localparam logic REC_FINAL   = 1'b1;

    // Final status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_MAGIC   = 3'd1,
        ST_VERSION = 3'd2,
        ST_ID      = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_LEB     = 3'd5,
        ST_NOCODE  = 3'd6
    } status_t;

    // One queue entry: an optional section record and an optional final status
    typedef struct packed {
        logic        sec_valid;
        logic [7:0]  section_id;
        logic [31:0] section_size;
        logic [31:0] content_offset;
        logic        fin_valid;
        status_t     status;
    } entry_t;

    // Queue fill status seen by the parser
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

FILE: design/wsd_if.sv
// ----------------------------------------------------------------------------
// wsd_if
// Valid/ready channels of the deframer: the byte stream in and the record
// stream out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface wsd_rec_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [7:0]  section_id;
    logic [31:0] section_size;
    logic [31:0] content_offset;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, output record_kind, output section_id,
                    output section_size, output content_offset, output status,
                    output last, input ready);
    modport sink   (input valid, input record_kind, input section_id,
                    input section_size, input content_offset, input status,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: design/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// Byte parser: holds the configuration registers, checks magic and version,
// frames sections and pushes section records and the final status into the
// queue, one byte a cycle while the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_front
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    wsd_byte_if.sink         byte_ch,
    input  wire queue_stat_t q_stat,
    output logic             q_push,
    output entry_t           q_entry
);

    typedef enum logic [5:0] {
        PH_MAGIC   = 6'b000001,
        PH_VERSION = 6'b000010,
        PH_ID      = 6'b000100,
        PH_SIZE    = 6'b001000,
        PH_SKIP    = 6'b010000,
        PH_DRAIN   = 6'b100000
    } phase_t;

    logic [31:0] magic_reg;
    logic [31:0] version_reg;
    logic [7:0]  id_limit_reg;
    logic [7:0]  code_id_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] shift_reg, shift_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] leb_reg, leb_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] offset_reg, offset_next;
    logic [7:0]  id_reg, id_next;
    logic        code_seen_reg, code_seen_next;
    status_t     error_reg, error_next;

    logic        accept;
    logic [31:0] shift_or;
    logic [31:0] leb_or;
    logic [6:0]  leb_bits;
    logic        leb_more;
    logic [2:0]  count_inc;
    logic        sec_valid;
    status_t     fin_status;

    // Take a byte whenever the queue has room
    assign byte_ch.ready = !q_stat.full;
    assign accept        = byte_ch.valid && byte_ch.ready;

    assign leb_bits  = byte_ch.data_byte[6:0];
    assign leb_more  = byte_ch.data_byte[7];
    assign count_inc = count_reg + 3'd1;

    // Place the byte into the little-endian word
    always_comb
    begin
        case (count_reg[1:0])
            2'd0:    shift_or = shift_reg | {24'd0, byte_ch.data_byte};
            2'd1:    shift_or = shift_reg | {16'd0, byte_ch.data_byte, 8'd0};
            2'd2:    shift_or = shift_reg | {8'd0, byte_ch.data_byte, 16'd0};
            default: shift_or = shift_reg | {byte_ch.data_byte, 24'd0};
        endcase
    end

    // Place seven LEB bits at their group; the fifth group keeps four bits
    always_comb
    begin
        case (count_reg)
            3'd0:    leb_or = leb_reg | {25'd0, leb_bits};
            3'd1:    leb_or = leb_reg | {18'd0, leb_bits, 7'd0};
            3'd2:    leb_or = leb_reg | {11'd0, leb_bits, 14'd0};
            3'd3:    leb_or = leb_reg | {4'd0, leb_bits, 21'd0};
            default: leb_or = leb_reg | {leb_bits[3:0], 28'd0};
        endcase
    end

    // Advance the parse state by one byte
    always_comb
    begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        count_next     = count_reg;
        leb_next       = leb_reg;
        skip_next      = skip_reg;
        offset_next    = offset_reg + 32'd1;
        id_next        = id_reg;
        code_seen_next = code_seen_reg;
        error_next     = error_reg;
        sec_valid      = 1'b0;
        fin_status     = ST_OK;

        case (phase_reg)
            PH_MAGIC, PH_VERSION:
            begin
                shift_next = shift_or;
                count_next = count_inc;
                if (count_inc[2])
                begin
                    if (shift_or != ((phase_reg == PH_MAGIC) ? magic_reg : version_reg))
                    begin
                        phase_next = PH_DRAIN;
                        error_next = (phase_reg == PH_MAGIC) ? ST_MAGIC : ST_VERSION;
                    end
                    else
                    begin
                        phase_next = (phase_reg == PH_MAGIC) ? PH_VERSION : PH_ID;
                        shift_next = 32'd0;
                        count_next = 3'd0;
                    end
                end
            end
            PH_ID:
            begin
                if (byte_ch.data_byte >= id_limit_reg)
                begin
                    phase_next = PH_DRAIN;
                    error_next = ST_ID;
                end
                else
                begin
                    id_next    = byte_ch.data_byte;
                    phase_next = PH_SIZE;
                    count_next = 3'd0;
                    leb_next   = 32'd0;
                end
            end
            PH_SIZE:
            begin
                if (count_reg >= 3'd4 && (leb_more || leb_bits > 7'h0F))
                begin
                    phase_next = PH_DRAIN;
                    error_next = ST_LEB;
                end
                else
                begin
                    leb_next   = leb_or;
                    count_next = count_inc;
                    if (!leb_more)
                    begin
                        sec_valid  = 1'b1;
                        count_next = 3'd0;
                        if (id_reg == code_id_reg)
                        begin
                            code_seen_next = 1'b1;
                        end
                        if (leb_or == 32'd0)
                        begin
                            phase_next = PH_ID;
                        end
                        else
                        begin
                            skip_next  = leb_or;
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0)
                begin
                    phase_next = PH_ID;
                end
            end
            default:
            begin
                phase_next = PH_DRAIN;
            end
        endcase

        // Work out the final status from the state this byte leaves
        case (phase_next)
            PH_ID:   fin_status = code_seen_next ? ST_OK : ST_NOCODE;
            PH_SKIP: fin_status = code_seen_next ? ST_TRUNC : ST_NOCODE;
            PH_MAGIC, PH_VERSION, PH_SIZE: fin_status = ST_TRUNC;
            default: fin_status = error_next;
        endcase

        // End of file: return the parse state to reset for the next file
        if (byte_ch.end_of_file)
        begin
            phase_next     = PH_MAGIC;
            shift_next     = 32'd0;
            count_next     = 3'd0;
            leb_next       = 32'd0;
            skip_next      = 32'd0;
            offset_next    = 32'd0;
            id_next        = 8'd0;
            code_seen_next = 1'b0;
            error_next     = ST_OK;
        end
    end

    // Build the queue entry
    always_comb
    begin
        q_entry.sec_valid      = sec_valid;
        q_entry.section_id     = id_reg;
        q_entry.section_size   = leb_or;
        q_entry.content_offset = offset_reg + 32'd1;
        q_entry.fin_valid      = byte_ch.end_of_file;
        q_entry.status         = fin_status;
    end

    assign q_push = accept && (sec_valid || byte_ch.end_of_file);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg    <= MAGIC_RESET;
            version_reg  <= VERSION_RESET;
            id_limit_reg <= ID_LIMIT_RESET;
            code_id_reg  <= CODE_ID_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MAGIC_WORD:       magic_reg    <= cfg_data;
                CFG_VERSION_WORD:     version_reg  <= cfg_data;
                CFG_SECTION_ID_LIMIT: id_limit_reg <= cfg_data[7:0];
                CFG_CODE_SECTION_ID:  code_id_reg  <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            shift_reg     <= 32'd0;
            count_reg     <= 3'd0;
            leb_reg       <= 32'd0;
            skip_reg      <= 32'd0;
            offset_reg    <= 32'd0;
            id_reg        <= 8'd0;
            code_seen_reg <= 1'b0;
            error_reg     <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            leb_reg       <= leb_next;
            skip_reg      <= skip_next;
            offset_reg    <= offset_next;
            id_reg        <= id_next;
            code_seen_reg <= code_seen_next;
            error_reg     <= error_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue
// Short register queue of parser entries between parser and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_queue
    import wsd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      head,
    output queue_stat_t stat
);

    entry_t                store_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;

    assign stat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = store_reg[rd_ptr_reg];

    // Write the entry at the tail
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: pops queue entries and presents one record a cycle, while the
// receiver is ready, from an output register; an entry with both a section
// record and a final status takes two transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_back
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire entry_t      head,
    input  wire queue_stat_t q_stat,
    output logic             pop,
    wsd_rec_if.source        rec_ch
);

    logic        valid_reg;
    logic        kind_reg;
    logic [7:0]  id_reg;
    logic [31:0] size_reg;
    logic [31:0] offset_reg;
    status_t     status_reg;
    logic        pend_reg;
    status_t     pend_status_reg;
    logic        load;

    // Reload the output register when empty or when its record is taken
    assign load = !valid_reg || rec_ch.ready;
    assign pop  = load && !pend_reg && !q_stat.empty;

    assign rec_ch.valid          = valid_reg;
    assign rec_ch.record_kind    = kind_reg;
    assign rec_ch.section_id     = id_reg;
    assign rec_ch.section_size   = size_reg;
    assign rec_ch.content_offset = offset_reg;
    assign rec_ch.status         = status_reg;
    assign rec_ch.last           = kind_reg;

    // Control: output valid and held final status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else if (pop)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= head.sec_valid && head.fin_valid;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg || (pop && !head.sec_valid))
            begin
                kind_reg   <= REC_FINAL;
                id_reg     <= 8'd0;
                size_reg   <= 32'd0;
                offset_reg <= 32'd0;
                status_reg <= pend_reg ? pend_status_reg : head.status;
            end
            else if (pop)
            begin
                kind_reg        <= REC_SECTION;
                id_reg          <= head.section_id;
                size_reg        <= head.section_size;
                offset_reg      <= head.content_offset;
                status_reg      <= ST_OK;
                pend_status_reg <= head.status;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/wasm_section_deframer_top.sv
// ----------------------------------------------------------------------------
// wasm_section_deframer_top
// Streaming section framer for WebAssembly module files: checks magic and
// version, frames sections and reports one record per section header and a
// final status per file.
//
//  channel   dir  handshake     payload
//  byte_ch   in   valid/ready   data_byte[7:0], end_of_file
//  rec_ch    out  valid/ready   record_kind, section_id[7:0], section_size[31:0],
//                               content_offset[31:0], status[2:0], last
//  cfg       in   cfg_wr_en     cfg_index[2:0], cfg_data[31:0]
//
// One byte is accepted per cycle while the four-entry queue has room; the
// parser updates its state in that cycle. Each record leaves from the output
// register, loaded from the queue head when empty or taken; a byte that gives
// both a section record and a final status needs two output transfers.
// Reset is asynchronous, active low, and starts a new file at offset zero.
// A stall on rec_ch fills the queue, after which byte_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module wasm_section_deframer_top
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    wsd_byte_if.sink         byte_ch,
    wsd_rec_if.source        rec_ch
);

    logic        q_push;
    logic        q_pop;
    entry_t      q_entry;
    entry_t      q_head;
    queue_stat_t q_stat;

    wsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_ch   (byte_ch),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    wsd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .pop    (q_pop),
        .rec_ch (rec_ch)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // A section record carries status ok and is never the last record
    a_section_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_ch.valid && rec_ch.record_kind == REC_SECTION)
            |-> (rec_ch.status == ST_OK && !rec_ch.last))
        else $error("section record with status or last set");

    // A queue entry with a record leads to a valid output in the next cycle
    a_output_follows: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> rec_ch.valid)
        else $error("popped entry not presented");

endmodule

`default_nettype wire

FILE: verif/wsd_record_checker.sv
// ----------------------------------------------------------------------------
// wsd_record_checker
// Watches the byte and record channels of the section deframer, keeps its own
// copy of the framing state and configuration, predicts the section and final
// status records for every byte transfer and compares each record transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module wsd_record_checker
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    wsd_byte_if              byte_ch,
    wsd_rec_if               rec_ch,
    output int unsigned      fail_count,
    output int unsigned      waiting,
    output int unsigned      parsed_count
);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_VERSION,
        PH_ID,
        PH_SIZE,
        PH_SKIP,
        PH_DRAIN
    } parse_phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  id;
        logic [31:0] size;
        logic [31:0] content_offset;
        status_t     status;
        logic        last;
    } record_t;

    // Mirrored configuration
    logic [31:0]  magic_reg;
    logic [31:0]  version_reg;
    logic [7:0]   id_limit_reg;
    logic [7:0]   code_id_reg;

    // Mirrored framing state
    parse_phase_t phase;
    logic [31:0]  word_shift;
    logic [2:0]   byte_count;
    logic [31:0]  leb_accum;
    logic [31:0]  bytes_to_skip;
    logic [31:0]  file_offset;
    logic [7:0]   current_id;
    logic         code_seen;
    status_t      error_code;

    record_t      pending_records[$];
    int unsigned  errors;
    int unsigned  parsed;

    task automatic clear_file_state();
        phase         = PH_MAGIC;
        word_shift    = '0;
        byte_count    = '0;
        leb_accum     = '0;
        bytes_to_skip = '0;
        file_offset   = '0;
        current_id    = '0;
        code_seen     = 1'b0;
        error_code    = ST_OK;
    endtask

    // Latch the first error and swallow bytes up to end of file
    task automatic fail_file(input status_t code);
        phase      = PH_DRAIN;
        error_code = code;
    endtask

    function automatic status_t end_status();
        case (phase)
            PH_ID:                         return code_seen ? ST_OK : ST_NOCODE;
            PH_SKIP:                       return code_seen ? ST_TRUNC : ST_NOCODE;
            PH_MAGIC, PH_VERSION, PH_SIZE: return ST_TRUNC;
            default:                       return error_code;
        endcase
    endfunction

    // Advance the framing state by one byte and queue the records it yields
    task automatic frame_byte(input logic [7:0] data, input logic eof);
        record_t     rec;
        logic [31:0] want;
        logic [31:0] bits;
        logic [2:0]  idx;

        file_offset = file_offset + 32'd1;
        case (phase)
            PH_MAGIC, PH_VERSION:
            begin
                word_shift = word_shift | ({24'd0, data} << (8 * byte_count[1:0]));
                byte_count = byte_count + 3'd1;
                if (byte_count >= 3'd4)
                begin
                    want = (phase == PH_MAGIC) ? magic_reg : version_reg;
                    if (word_shift != want)
                    begin
                        fail_file((phase == PH_MAGIC) ? ST_MAGIC : ST_VERSION);
                    end
                    else
                    begin
                        phase      = (phase == PH_MAGIC) ? PH_VERSION : PH_ID;
                        word_shift = '0;
                        byte_count = '0;
                    end
                end
            end
            PH_ID:
            begin
                if (data >= id_limit_reg)
                begin
                    fail_file(ST_ID);
                end
                else
                begin
                    current_id = data;
                    phase      = PH_SIZE;
                    byte_count = '0;
                    leb_accum  = '0;
                end
            end
            PH_SIZE:
            begin
                idx  = byte_count;
                bits = {25'd0, data[6:0]};
                // Fifth size byte may carry only four value bits and no continuation
                if (idx >= 3'd4 && (data[7] || bits > 32'd15))
                begin
                    fail_file(ST_LEB);
                end
                else
                begin
                    if (idx > 3'd4)
                        idx = 3'd4;
                    leb_accum  = leb_accum | (bits << (7 * idx));
                    byte_count = byte_count + 3'd1;
                    if (!data[7])
                    begin
                        rec.kind           = REC_SECTION;
                        rec.id             = current_id;
                        rec.size           = leb_accum;
                        rec.content_offset = file_offset;
                        rec.status         = ST_OK;
                        rec.last           = 1'b0;
                        pending_records.push_back(rec);
                        if (current_id == code_id_reg)
                            code_seen = 1'b1;
                        if (leb_accum == '0)
                        begin
                            phase = PH_ID;
                        end
                        else
                        begin
                            bytes_to_skip = leb_accum;
                            phase         = PH_SKIP;
                        end
                        byte_count = '0;
                    end
                end
            end
            PH_SKIP:
            begin
                bytes_to_skip = bytes_to_skip - 32'd1;
                if (bytes_to_skip == '0)
                    phase = PH_ID;
            end
            default:
            begin
                phase = PH_DRAIN;
            end
        endcase

        // End of file: queue the final status and start a fresh file
        if (eof)
        begin
            rec.kind           = REC_FINAL;
            rec.id             = '0;
            rec.size           = '0;
            rec.content_offset = '0;
            rec.status         = end_status();
            rec.last           = 1'b1;
            pending_records.push_back(rec);
            clear_file_state();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] actual);
        if (actual !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, actual);
            errors++;
        end
    endtask

    // Track configuration, predict on byte transfers, compare on record transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg    = MAGIC_RESET;
            version_reg  = VERSION_RESET;
            id_limit_reg = ID_LIMIT_RESET;
            code_id_reg  = CODE_ID_RESET;
            clear_file_state();
            pending_records.delete();
            errors       = 0;
            parsed       = 0;
            fail_count   <= 0;
            waiting      <= 0;
            parsed_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MAGIC_WORD:       magic_reg    = cfg_data;
                    CFG_VERSION_WORD:     version_reg  = cfg_data;
                    CFG_SECTION_ID_LIMIT: id_limit_reg = cfg_data[7:0];
                    CFG_CODE_SECTION_ID:  code_id_reg  = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (byte_ch.valid && byte_ch.ready)
            begin
                if (phase != PH_DRAIN)
                    parsed++;
                frame_byte(byte_ch.data_byte, byte_ch.end_of_file);
            end

            if (rec_ch.valid && rec_ch.ready)
            begin
                if (pending_records.size() == 0)
                begin
                    $error("record transfer with none predicted: kind %0d status %0d",
                           rec_ch.record_kind, rec_ch.status);
                    errors++;
                end
                else
                begin
                    record_t head;
                    head = pending_records.pop_front();
                    check_field("record_kind", head.kind, rec_ch.record_kind);
                    check_field("section_id", head.id, rec_ch.section_id);
                    check_field("section_size", head.size, rec_ch.section_size);
                    check_field("content_offset", head.content_offset,
                                rec_ch.content_offset);
                    check_field("status", head.status, rec_ch.status);
                    check_field("last", head.last, rec_ch.last);
                end
            end

            fail_count   <= errors;
            waiting      <= pending_records.size();
            parsed_count <= parsed;
        end
    end

endmodule

FILE: verif/wasm_section_deframer_top_tb.sv
// ----------------------------------------------------------------------------
// wasm_section_deframer_top_tb
// Feeds the section deframer with generated module files: mostly well-formed
// files with random sections and content, plus truncated files, bad magic or
// version words, bad ids, over-long size fields, huge sizes and noise. Runs
// through several register settings with random idling on both channels and
// leaves the checking to the record checker beside the block.
// ----------------------------------------------------------------------------
module wasm_section_deframer_top_tb;

    import wsd_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = CFG_MAGIC_WORD;
    logic [31:0] cfg_data  = '0;
    logic        calm      = 1'b0;

    int unsigned fail_count;
    int unsigned waiting;
    int unsigned parsed_count;

    // Register values as last written, used to shape the files
    logic [31:0] magic_cfg   = MAGIC_RESET;
    logic [31:0] version_cfg = VERSION_RESET;
    logic [7:0]  limit_cfg   = ID_LIMIT_RESET;
    logic [7:0]  code_cfg    = CODE_ID_RESET;

    logic [7:0]  file_bytes[$];

    wsd_byte_if byte_ch ();
    wsd_rec_if  rec_ch ();

    wasm_section_deframer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_ch   (byte_ch),
        .rec_ch    (rec_ch)
    );

    wsd_record_checker record_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_ch      (byte_ch),
        .rec_ch       (rec_ch),
        .fail_count   (fail_count),
        .waiting      (waiting),
        .parsed_count (parsed_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Record sink: random stall bursts, none once the run turns calm
    initial
    begin
        rec_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                rec_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            rec_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_MAGIC_WORD:       magic_cfg   = value;
            CFG_VERSION_WORD:     version_cfg = value;
            CFG_SECTION_ID_LIMIT: limit_cfg   = value[7:0];
            CFG_CODE_SECTION_ID:  code_cfg    = value[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop valid and hold until every predicted record has left the block
    task automatic settle();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_setting(input int step);
        case (step)
            1:
            begin
                write_reg(CFG_MAGIC_WORD, 32'h0000_0000);
                write_reg(CFG_VERSION_WORD, 32'hFFFF_FFFF);
                write_reg(CFG_SECTION_ID_LIMIT, 32'd255);
                write_reg(CFG_CODE_SECTION_ID, 32'd0);
            end
            2:
            begin
                write_reg(CFG_MAGIC_WORD, 32'hFFFF_FFFF);
                write_reg(CFG_VERSION_WORD, 32'h0000_0000);
                write_reg(CFG_SECTION_ID_LIMIT, 32'd1);
                write_reg(CFG_CODE_SECTION_ID, 32'd255);
            end
            3:
            begin
                // A limit of zero rejects every id
                write_reg(CFG_MAGIC_WORD, $urandom);
                write_reg(CFG_VERSION_WORD, $urandom);
                write_reg(CFG_SECTION_ID_LIMIT, 32'd0);
                write_reg(CFG_CODE_SECTION_ID, $urandom_range(0, 7));
            end
            4:
            begin
                write_reg(CFG_MAGIC_WORD, $urandom);
                write_reg(CFG_VERSION_WORD, $urandom_range(0, 3));
                write_reg(CFG_SECTION_ID_LIMIT, $urandom_range(1, 255));
                write_reg(CFG_CODE_SECTION_ID, $urandom_range(0, limit_cfg));
            end
            default:
            begin
                write_reg(CFG_MAGIC_WORD, MAGIC_RESET);
                write_reg(CFG_VERSION_WORD, VERSION_RESET);
                write_reg(CFG_SECTION_ID_LIMIT, {24'd0, ID_LIMIT_RESET});
                write_reg(CFG_CODE_SECTION_ID, {24'd0, CODE_ID_RESET});
            end
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_word(input logic [31:0] word);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(word[8*i +: 8]);
    endtask

    // Unsigned LEB128, optionally padded with redundant continuation groups
    task automatic push_leb(input logic [31:0] value, input int pad);
        int          groups;
        int          total;
        logic [31:0] group;

        groups = 1;
        while (groups < 5 && (value >> (7 * groups)) != 0)
            groups++;
        total = (groups + pad > 5) ? 5 : groups + pad;
        for (int i = 0; i < total; i++)
        begin
            group = value >> (7 * i);
            file_bytes.push_back({i != total - 1, group[6:0]});
        end
    endtask

    task automatic push_junk(input int most);
        repeat ($urandom_range(0, most))
            file_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [7:0] good_id();
        if (limit_cfg != 0 && code_cfg < limit_cfg && $urandom_range(0, 2) == 0)
            return code_cfg;
        if (limit_cfg == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, limit_cfg - 1));
    endfunction

    // Mostly short contents, now and then a two-byte size field
    function automatic logic [31:0] section_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return 32'd0;
        if (pick < 8)
            return $urandom_range(1, 8);
        if (pick < 9)
            return $urandom_range(9, 40);
        return $urandom_range(41, 130);
    endfunction

    task automatic push_sections(input int count);
        logic [31:0] size;
        int          pad;

        repeat (count)
        begin
            size = section_size();
            pad  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            file_bytes.push_back(good_id());
            push_leb(size, pad);
            repeat (size)
                file_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic build_file();
        int          pick;
        int          cut;
        logic [31:0] huge;

        file_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            // Well-formed file, cut short now and then
            push_word(magic_cfg);
            push_word(version_cfg);
            push_sections($urandom_range(0, 5));
            if (pick >= 64)
            begin
                cut = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > cut)
                    void'(file_bytes.pop_back());
            end
        end
        else if (pick < 78)
        begin
            // Flip one bit of the magic or the version word
            if ($urandom_range(0, 1) == 0)
            begin
                push_word(magic_cfg ^ (32'd1 << $urandom_range(0, 31)));
            end
            else
            begin
                push_word(magic_cfg);
                push_word(version_cfg ^ (32'd1 << $urandom_range(0, 31)));
            end
            push_junk(6);
        end
        else if (pick < 84)
        begin
            // Section id at or above the limit
            push_word(magic_cfg);
            push_word(version_cfg);
            push_sections($urandom_range(0, 2));
            file_bytes.push_back(8'($urandom_range(limit_cfg, 255)));
            push_junk(6);
        end
        else if (pick < 90)
        begin
            // Size field that runs past five bytes or past 32 bits
            push_word(magic_cfg);
            push_word(version_cfg);
            push_sections($urandom_range(0, 1));
            file_bytes.push_back(good_id());
            repeat (4)
                file_bytes.push_back({1'b1, 7'($urandom)});
            if ($urandom_range(0, 1) == 0)
                file_bytes.push_back({1'b1, 7'($urandom)});
            else
                file_bytes.push_back({1'b0, 7'($urandom_range(16, 127))});
            push_junk(6);
        end
        else if (pick < 95)
        begin
            // Huge section whose content is never complete
            push_word(magic_cfg);
            push_word(version_cfg);
            push_sections($urandom_range(0, 1));
            file_bytes.push_back(good_id());
            huge = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h0100_0000);
            push_leb(huge, 0);
            push_junk(8);
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                file_bytes.push_back(8'($urandom));
        end
    endtask

    // One byte transfer, after an occasional idle burst
    task automatic send_byte(input logic [7:0] data, input logic eof);
        if (!calm && $urandom_range(0, 11) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= data;
        byte_ch.end_of_file <= eof;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Stimulus and verdict
    initial
    begin
        int unsigned target;

        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= '0;
        byte_ch.end_of_file <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one all-ones byte ends the file inside the magic word
        file_bytes.delete();
        file_bytes.push_back(8'hFF);
        send_file();
        // Code section of size zero whose size byte also ends the file
        file_bytes.delete();
        push_word(magic_cfg);
        push_word(version_cfg);
        file_bytes.push_back(code_cfg);
        push_leb(32'd0, 0);
        send_file();
        // File with no section at all
        file_bytes.delete();
        push_word(magic_cfg);
        push_word(version_cfg);
        send_file();

        target = 0;
        for (int step = 0; step < 6; step++)
        begin
            if (step > 0)
            begin
                settle();
                apply_setting(step);
            end
            calm = (step == 5);
            target += 150;
            while (parsed_count < target)
            begin
                build_file();
                send_file();
            end
        end

        // Drain the remaining records
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && waiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: wasm_section_deframer_top.f
design/wsd_pkg.sv
design/wsd_if.sv
design/wsd_front.sv
design/wsd_queue.sv
design/wsd_back.sv
design/wasm_section_deframer_top.sv
verif/wsd_record_checker.sv
verif/wasm_section_deframer_top_tb.sv
